// File: rtl/mqs_pkg.sv
// Shared types, constants and the symbol-to-ASCII function for the marquee scroller.
package mqs_pkg;

    localparam int MSG_SLOTS    = 16;
    localparam int WINDOW_WIDTH = 16;

    localparam int SLOT_W  = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
    localparam int LEN_W   = $clog2(MSG_SLOTS + 1);
    localparam int SPAN_W  = $clog2(MSG_SLOTS + WINDOW_WIDTH + 1);
    localparam int IDX_W   = (WINDOW_WIDTH > 1) ? $clog2(WINDOW_WIDTH) : 1;
    localparam int SYM_W   = 6;
    localparam int COL_W   = 5;
    localparam int CHAR_W  = 7;
    localparam int PER_W   = 16;

    localparam logic [SYM_W-1:0]  SYM_LAST       = SYM_W'(35);
    localparam logic [SYM_W-1:0]  SYM_ALPHA      = SYM_W'(10);
    localparam logic [SYM_W-1:0]  SYM_COUNT      = SYM_W'(36);
    localparam logic [COL_W-1:0]  EDIT_COL       = COL_W'(6);
    localparam logic [PER_W-1:0]  PERIOD_RESET   = PER_W'(1000);
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CHAR_ZERO      = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = CHAR_W'(55);

    localparam logic [2:0] KEY_UP      = 3'd0;
    localparam logic [2:0] KEY_DOWN    = 3'd1;
    localparam logic [2:0] KEY_FORWARD = 3'd2;
    localparam logic [2:0] KEY_BACK    = 3'd3;
    localparam logic [2:0] KEY_START   = 3'd4;
    localparam logic [2:0] KEY_RETURN  = 3'd5;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [2:0] key_code;
    } in_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } out_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [SYM_W-1:0]  data;
    } mem_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYM,
        ST_ZERO,
        ST_SHOW,
        ST_MOD,
        ST_REFLECT,
        ST_EMIT
    } state_t;

    function automatic logic [CHAR_W-1:0] sym_char(input logic [SYM_W-1:0] s);
        logic [CHAR_W-1:0] ch;
        if (s < SYM_ALPHA)
            ch = CHAR_ZERO + CHAR_W'(s);
        else if (s < SYM_COUNT)
            ch = CHAR_ALPHA_OFS + CHAR_W'(s);
        else
            ch = CHAR_ZERO;
        return ch;
    endfunction

endpackage

// File: rtl/mqs_msg_mem.sv
// Message symbol store with per-slot valid bits and registered read port.
module mqs_msg_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mqs_pkg::mem_wr_t              wr,
    input  logic                          rd_en,
    input  logic [mqs_pkg::SLOT_W-1:0]    rd_addr,
    output logic [mqs_pkg::SYM_W-1:0]     rd_data
);

    logic [mqs_pkg::SYM_W-1:0]     mem [mqs_pkg::MSG_SLOTS];
    logic [mqs_pkg::MSG_SLOTS-1:0] valid_reg;
    logic [mqs_pkg::SYM_W-1:0]     rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/marquee_text_editor_scroller_core.sv
// Marquee controller top level: edit/scroll sequencer with shared subtract-compare unit.
// Keys with a result go through ST_SYM, ST_ZERO or ST_SHOW to the output register.
// Scroll step: modulo and reflect, then one window character per cycle unless the output
// stalls (16 characters), paced by the message store read port and the output register.
// One transaction at a time: a new input is taken only after the previous run is queued.
// rst_n clears all control state; period returns to 1000, message slots read as '0'.
module marquee_text_editor_scroller_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mqs_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mqs_pkg::out_t               out_data,
    input  logic                        cfg_we,
    input  logic [mqs_pkg::PER_W-1:0]   cfg_wdata
);

    mqs_pkg::state_t                state_reg, state_next;
    logic [mqs_pkg::SLOT_W-1:0]     cursor_reg, cursor_next;
    logic [mqs_pkg::LEN_W-1:0]      length_reg, length_next;
    logic                           scroll_mode_reg, scroll_mode_next;
    logic                           dir_right_reg, dir_right_next;
    logic                           running_reg, running_next;
    logic [mqs_pkg::SPAN_W-1:0]     window_index_reg, window_index_next;
    logic [mqs_pkg::PER_W-1:0]      tick_count_reg, tick_count_next;
    logic [mqs_pkg::PER_W-1:0]      period_reg, period_next;
    logic                           step_up_reg, step_up_next;
    logic [mqs_pkg::SPAN_W-1:0]     pos_reg, pos_next;
    logic [mqs_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                           msg_hit_reg, msg_hit_next;
    logic                           out_valid_reg, out_valid_next;
    mqs_pkg::out_t                  out_reg, out_next;

    mqs_pkg::mem_wr_t               mem_wr;
    logic                           rd_en;
    logic [mqs_pkg::SLOT_W-1:0]     rd_addr;
    logic [mqs_pkg::SYM_W-1:0]      rd_data;

    logic [mqs_pkg::SPAN_W-1:0]     alu_a, alu_b;
    logic [mqs_pkg::SPAN_W:0]       alu_diff;
    logic                           alu_ge;

    logic [mqs_pkg::SPAN_W-1:0]     span;
    logic [mqs_pkg::COL_W-1:0]      edit_col;
    logic                           out_free;
    logic [mqs_pkg::PER_W:0]        tick_sum;
    logic [mqs_pkg::SYM_W-1:0]      cur_sym;
    logic [mqs_pkg::SYM_W-1:0]      new_sym;
    logic [mqs_pkg::SPAN_W-1:0]     base_inc;
    logic [mqs_pkg::SPAN_W-1:0]     start_pos;
    logic [mqs_pkg::SPAN_W-1:0]     pos_inc;
    logic [mqs_pkg::SPAN_W-1:0]     new_pos;

    mqs_msg_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign span     = mqs_pkg::SPAN_W'(length_reg) + mqs_pkg::SPAN_W'(mqs_pkg::WINDOW_WIDTH);
    assign edit_col = mqs_pkg::EDIT_COL + mqs_pkg::COL_W'(cursor_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign tick_sum = {1'b0, tick_count_reg} + (mqs_pkg::PER_W+1)'(1);
    assign cur_sym  = (rd_data < mqs_pkg::SYM_COUNT) ? rd_data : '0;
    assign base_inc = pos_reg + mqs_pkg::SPAN_W'(1);
    assign pos_inc  = pos_reg + mqs_pkg::SPAN_W'(1);

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = !alu_diff[mqs_pkg::SPAN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mqs_pkg::ST_IDLE;
            cursor_reg       <= '0;
            length_reg       <= mqs_pkg::LEN_W'(1);
            scroll_mode_reg  <= 1'b0;
            dir_right_reg    <= 1'b0;
            running_reg      <= 1'b0;
            window_index_reg <= '0;
            tick_count_reg   <= '0;
            period_reg       <= mqs_pkg::PERIOD_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cursor_reg       <= cursor_next;
            length_reg       <= length_next;
            scroll_mode_reg  <= scroll_mode_next;
            dir_right_reg    <= dir_right_next;
            running_reg      <= running_next;
            window_index_reg <= window_index_next;
            tick_count_reg   <= tick_count_next;
            period_reg       <= period_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_up_reg <= step_up_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        msg_hit_reg <= msg_hit_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        cursor_next       = cursor_reg;
        length_next       = length_reg;
        scroll_mode_next  = scroll_mode_reg;
        dir_right_next    = dir_right_reg;
        running_next      = running_reg;
        window_index_next = window_index_reg;
        tick_count_next   = tick_count_reg;
        period_next       = cfg_we ? cfg_wdata : period_reg;
        step_up_next      = step_up_reg;
        pos_next          = pos_reg;
        idx_next          = idx_reg;
        msg_hit_next      = msg_hit_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_next          = out_reg;
        mem_wr            = '0;
        rd_en             = 1'b0;
        rd_addr           = cursor_reg;
        alu_a             = pos_reg;
        alu_b             = span;
        in_ready          = (state_reg == mqs_pkg::ST_IDLE);
        new_sym           = '0;
        start_pos         = pos_reg;
        new_pos           = pos_inc;

        unique case (state_reg)
            mqs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.kind == mqs_pkg::KIND_TICK)
                    begin
                        if (scroll_mode_reg && running_reg)
                        begin
                            if (tick_sum > {1'b0, period_reg})
                            begin
                                tick_count_next = '0;
                                pos_next        = window_index_reg;
                                state_next      = mqs_pkg::ST_MOD;
                            end
                            else
                            begin
                                tick_count_next = tick_sum[mqs_pkg::PER_W-1:0];
                            end
                        end
                    end
                    else if (scroll_mode_reg)
                    begin
                        unique case (in_data.key_code)
                            mqs_pkg::KEY_UP:    dir_right_next = 1'b0;
                            mqs_pkg::KEY_DOWN:  dir_right_next = 1'b1;
                            mqs_pkg::KEY_START: running_next   = !running_reg;
                            mqs_pkg::KEY_RETURN:
                            begin
                                scroll_mode_next = 1'b0;
                                cursor_next      = '0;
                                rd_en            = 1'b1;
                                rd_addr          = '0;
                                state_next       = mqs_pkg::ST_SHOW;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else
                    begin
                        unique case (in_data.key_code) inside
                            mqs_pkg::KEY_UP, mqs_pkg::KEY_DOWN:
                            begin
                                step_up_next = (in_data.key_code == mqs_pkg::KEY_UP);
                                rd_en        = 1'b1;
                                state_next   = mqs_pkg::ST_SYM;
                            end
                            mqs_pkg::KEY_FORWARD:
                            begin
                                if (cursor_reg != mqs_pkg::SLOT_W'(mqs_pkg::MSG_SLOTS - 1))
                                begin
                                    cursor_next = cursor_reg + mqs_pkg::SLOT_W'(1);
                                    length_next = mqs_pkg::LEN_W'(cursor_reg)
                                                + mqs_pkg::LEN_W'(2);
                                    mem_wr.en   = 1'b1;
                                    mem_wr.addr = cursor_reg + mqs_pkg::SLOT_W'(1);
                                    state_next  = mqs_pkg::ST_ZERO;
                                end
                            end
                            mqs_pkg::KEY_BACK:
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cursor_next = cursor_reg - mqs_pkg::SLOT_W'(1);
                                    length_next = mqs_pkg::LEN_W'(cursor_reg);
                                    mem_wr.en   = 1'b1;
                                    mem_wr.addr = cursor_reg - mqs_pkg::SLOT_W'(1);
                                    state_next  = mqs_pkg::ST_ZERO;
                                end
                            end
                            mqs_pkg::KEY_START:
                            begin
                                scroll_mode_next  = 1'b1;
                                window_index_next = '0;
                                running_next      = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            mqs_pkg::ST_SYM:
            begin
                if (step_up_reg)
                    new_sym = (cur_sym == mqs_pkg::SYM_LAST) ? '0
                                                             : cur_sym + mqs_pkg::SYM_W'(1);
                else
                    new_sym = (cur_sym == '0) ? mqs_pkg::SYM_LAST
                                              : cur_sym - mqs_pkg::SYM_W'(1);
                if (out_free)
                begin
                    mem_wr.en          = 1'b1;
                    mem_wr.addr        = cursor_reg;
                    mem_wr.data        = new_sym;
                    out_valid_next     = 1'b1;
                    out_next.column    = edit_col;
                    out_next.char_code = mqs_pkg::sym_char(new_sym);
                    out_next.last      = 1'b1;
                    state_next         = mqs_pkg::ST_IDLE;
                end
            end

            mqs_pkg::ST_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.column    = edit_col;
                    out_next.char_code = mqs_pkg::CHAR_ZERO;
                    out_next.last      = 1'b1;
                    state_next         = mqs_pkg::ST_IDLE;
                end
            end

            mqs_pkg::ST_SHOW:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.column    = edit_col;
                    out_next.char_code = mqs_pkg::sym_char(rd_data);
                    out_next.last      = 1'b1;
                    state_next         = mqs_pkg::ST_IDLE;
                end
            end

            mqs_pkg::ST_MOD:
            begin
                alu_a = pos_reg;
                alu_b = span;
                if (alu_ge)
                begin
                    pos_next = alu_diff[mqs_pkg::SPAN_W-1:0];
                end
                else
                begin
                    window_index_next = (base_inc == span) ? '0 : base_inc;
                    state_next        = mqs_pkg::ST_REFLECT;
                end
            end

            mqs_pkg::ST_REFLECT:
            begin
                alu_a = span;
                alu_b = pos_reg;
                if (dir_right_reg && (pos_reg != '0))
                    start_pos = alu_diff[mqs_pkg::SPAN_W-1:0];
                pos_next     = start_pos;
                rd_en        = 1'b1;
                rd_addr      = start_pos[mqs_pkg::SLOT_W-1:0];
                msg_hit_next = (start_pos < mqs_pkg::SPAN_W'(length_reg));
                idx_next     = '0;
                state_next   = mqs_pkg::ST_EMIT;
            end

            mqs_pkg::ST_EMIT:
            begin
                alu_a   = pos_inc;
                alu_b   = span;
                new_pos = alu_ge ? alu_diff[mqs_pkg::SPAN_W-1:0] : pos_inc;
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.column    = mqs_pkg::COL_W'(idx_reg);
                    out_next.char_code = msg_hit_reg ? mqs_pkg::sym_char(rd_data)
                                                     : mqs_pkg::CHAR_SPACE;
                    out_next.last      = (idx_reg == mqs_pkg::IDX_W'(mqs_pkg::WINDOW_WIDTH - 1));
                    if (out_next.last)
                    begin
                        state_next = mqs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next     = idx_reg + mqs_pkg::IDX_W'(1);
                        pos_next     = new_pos;
                        rd_en        = 1'b1;
                        rd_addr      = new_pos[mqs_pkg::SLOT_W-1:0];
                        msg_hit_next = (new_pos < mqs_pkg::SPAN_W'(length_reg));
                    end
                end
            end

            default:
            begin
                state_next = mqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/mqs_checker.sv
// Port-level assertions for the marquee scroller top level, with bind.
module mqs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input mqs_pkg::in_t   in_data,
    input logic           out_valid,
    input logic           out_ready,
    input mqs_pkg::out_t  out_data
);

    // hold a waiting input transaction
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input changed while waiting");

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // block new input until a run is complete
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("input taken in the middle of a run");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.char_code == 7'd32)
                   || (out_data.char_code >= 7'd48 && out_data.char_code <= 7'd57)
                   || (out_data.char_code >= 7'd65 && out_data.char_code <= 7'd90))
        else $error("character outside digit, letter, space");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind marquee_text_editor_scroller_core mqs_checker u_mqs_checker (.*);

// File: test/marquee_text_editor_scroller_core_tb.sv
// Self-checking testbench for the marquee scroller core: directed key/tick table, then random traffic.
module marquee_text_editor_scroller_core_tb;

    localparam int CLK_PERIOD    = 20;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int IDLE_PCT      = 9;
    localparam int COL_BASE      = 6;
    localparam int SYM_TOP       = 35;
    localparam int CHAR_BLANK    = 32;
    localparam int DRILL_LEN     = 25;

    localparam logic [2:0] KEY_VOID_A = 3'd6;
    localparam logic [2:0] KEY_VOID_B = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [2:0] key;
        bit         typed;
        bit         writes;
        int         col;
        byte        ch;
    } drill_row_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_ready;
    mqs_pkg::in_t in_data   = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    mqs_pkg::out_t out_data;
    logic         cfg_we    = 1'b0;
    logic [mqs_pkg::PER_W-1:0] cfg_wdata = '0;

    bit           row_typed  = 1'b0;
    bit           row_writes = 1'b0;
    mqs_pkg::out_t row_char  = '0;

    bit           calm        = 1'b0;
    int unsigned  fault_count = 0;
    int unsigned  items_sent  = 0;

    mqs_pkg::out_t pending_chars [$];
    mqs_pkg::out_t step_chars [$];

    string        symbol_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    logic [5:0]   msg_sym [mqs_pkg::MSG_SLOTS];
    int unsigned  cursor     = 0;
    int unsigned  msg_len    = 1;
    bit           scrolling  = 1'b0;
    bit           to_right   = 1'b0;
    bit           running    = 1'b0;
    int unsigned  win_idx    = 0;
    int unsigned  ticks      = 0;
    int unsigned  period_cfg = mqs_pkg::PERIOD_RESET;

    drill_row_t drill [DRILL_LEN] = '{
        '{mqs_pkg::KIND_TICK, mqs_pkg::KEY_UP,      1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_RETURN,  1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  KEY_VOID_A,           1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  KEY_VOID_B,           1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_BACK,    1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_DOWN,    1'b1, 1'b1, 6, "Z"},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_UP,      1'b1, 1'b1, 6, "0"},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_UP,      1'b1, 1'b1, 6, "1"},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_FORWARD, 1'b1, 1'b1, 7, "0"},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_DOWN,    1'b1, 1'b1, 7, "Z"},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_FORWARD, 1'b1, 1'b1, 8, "0"},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_BACK,    1'b1, 1'b1, 7, "0"},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_START,   1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_TICK, KEY_VOID_B,           1'b0, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_DOWN,    1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_TICK, mqs_pkg::KEY_UP,      1'b0, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_START,   1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_TICK, mqs_pkg::KEY_UP,      1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_START,   1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_FORWARD, 1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_BACK,    1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  KEY_VOID_A,           1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_UP,      1'b1, 1'b0, 0, 0},
        '{mqs_pkg::KIND_TICK, mqs_pkg::KEY_UP,      1'b0, 1'b0, 0, 0},
        '{mqs_pkg::KIND_KEY,  mqs_pkg::KEY_RETURN,  1'b1, 1'b1, 6, "1"}
    };

    marquee_text_editor_scroller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        foreach (msg_sym[s])
            msg_sym[s] = '0;
    end

    function automatic logic [6:0] glyph(input logic [5:0] s);
        return 7'(symbol_set[s]);
    endfunction

    function automatic void note_char(input int col, input int ch, input bit fin);
        mqs_pkg::out_t e;
        e.column    = 5'(col);
        e.char_code = 7'(ch);
        e.last      = fin;
        step_chars.push_back(e);
    endfunction

    function automatic void echo_cursor();
        note_char(COL_BASE + cursor, glyph(msg_sym[cursor]), 1'b1);
    endfunction

    function automatic void move_cursor(input int unsigned slot);
        cursor = slot;
        msg_sym[slot] = '0;
        msg_len = slot + 1;
        echo_cursor();
    endfunction

    function automatic void advance_marquee(input mqs_pkg::in_t item);
        int unsigned span, start, pos, i, ch;
        logic [5:0] s;
        step_chars.delete();
        if (item.kind == mqs_pkg::KIND_TICK)
        begin
            if (scrolling && running)
            begin
                if (ticks + 1 <= period_cfg)
                    ticks = ticks + 1;
                else
                begin
                    ticks = 0;
                    span  = msg_len + mqs_pkg::WINDOW_WIDTH;
                    start = win_idx % span;
                    win_idx = (start + 1) % span;
                    if (to_right)
                        start = (span - start) % span;
                    for (i = 0; i < mqs_pkg::WINDOW_WIDTH; i++)
                    begin
                        pos = (start + i) % span;
                        ch  = (pos < msg_len) ? glyph(msg_sym[pos]) : CHAR_BLANK;
                        note_char(i, ch, i == mqs_pkg::WINDOW_WIDTH - 1);
                    end
                end
            end
        end
        else if (scrolling)
        begin
            case (item.key_code)
                mqs_pkg::KEY_UP:    to_right = 1'b0;
                mqs_pkg::KEY_DOWN:  to_right = 1'b1;
                mqs_pkg::KEY_START: running = !running;
                mqs_pkg::KEY_RETURN:
                begin
                    scrolling = 1'b0;
                    cursor = 0;
                    echo_cursor();
                end
                default: ;
            endcase
        end
        else
        begin
            s = msg_sym[cursor];
            case (item.key_code)
                mqs_pkg::KEY_UP:
                begin
                    msg_sym[cursor] = (s == SYM_TOP) ? 6'd0 : s + 6'd1;
                    echo_cursor();
                end
                mqs_pkg::KEY_DOWN:
                begin
                    msg_sym[cursor] = (s == 0) ? 6'(SYM_TOP) : s - 6'd1;
                    echo_cursor();
                end
                mqs_pkg::KEY_FORWARD:
                    if (cursor < mqs_pkg::MSG_SLOTS - 1)
                        move_cursor(cursor + 1);
                mqs_pkg::KEY_BACK:
                    if (cursor > 0)
                        move_cursor(cursor - 1);
                mqs_pkg::KEY_START:
                begin
                    scrolling = 1'b1;
                    win_idx = 0;
                    running = 1'b1;
                end
                default: ;
            endcase
        end
    endfunction

    always @(posedge clk)
    begin
        mqs_pkg::out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_marquee(in_data);
                if (row_typed)
                begin
                    if (row_writes)
                        pending_chars.push_back(row_char);
                end
                else
                    foreach (step_chars[k])
                        pending_chars.push_back(step_chars[k]);
            end
            if (out_valid && out_ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected transaction: column %0d char_code %0d last %0d",
                           out_data.column, out_data.char_code, out_data.last);
                    fault_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (out_data.column !== want.column)
                    begin
                        $error("column: expected %0d, actual %0d", want.column, out_data.column);
                        fault_count++;
                    end
                    if (out_data.char_code !== want.char_code)
                    begin
                        $error("char_code: expected %0d, actual %0d",
                               want.char_code, out_data.char_code);
                        fault_count++;
                    end
                    if (out_data.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, out_data.last);
                        fault_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    task automatic send_item(input logic kind, input logic [2:0] key, input bit typed,
                             input bit writes, input int col, input byte ch);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_data    <= '{kind: kind, key_code: key};
        row_typed  <= typed;
        row_writes <= writes;
        row_char   <= '{column: 5'(col), char_code: 7'(ch), last: 1'b1};
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send(input logic kind, input logic [2:0] key);
        send_item(kind, key, 1'b0, 1'b0, 0, 0);
    endtask

    task automatic await_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_period(input logic [mqs_pkg::PER_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        period_cfg = value;
    endtask

    task automatic run_random(input int unsigned goal);
        int unsigned stop, pick, n, r;
        stop = items_sent + goal;
        while (items_sent < stop)
        begin
            pick = $urandom_range(99);
            send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_RETURN);
            if (pick < 35)
            begin
                n = $urandom_range(10, 3);
                repeat (n)
                begin
                    r = $urandom_range(99);
                    send(mqs_pkg::KIND_KEY,
                         (r < 35) ? mqs_pkg::KEY_UP : (r < 60) ? mqs_pkg::KEY_DOWN :
                         (r < 85) ? mqs_pkg::KEY_FORWARD : mqs_pkg::KEY_BACK);
                end
            end
            else if (pick < 45)
            begin
                // fill every slot and push against the end
                repeat (mqs_pkg::MSG_SLOTS + 1)
                begin
                    send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_FORWARD);
                    if ($urandom_range(1))
                        send(mqs_pkg::KIND_KEY,
                             $urandom_range(1) ? mqs_pkg::KEY_UP : mqs_pkg::KEY_DOWN);
                end
            end
            else if (pick < 88)
            begin
                send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_START);
                n = $urandom_range(12, 4);
                repeat (n)
                begin
                    r = $urandom_range(99);
                    if (r < 65)
                        send(mqs_pkg::KIND_TICK, 3'($urandom_range(7)));
                    else if (r < 75)
                        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_UP);
                    else if (r < 85)
                        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_DOWN);
                    else if (r < 93)
                        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_START);
                    else
                        send(mqs_pkg::KIND_KEY, 3'($urandom_range(7)));
                end
            end
            else
            begin
                n = $urandom_range(6, 2);
                repeat (n)
                    send(1'($urandom_range(1)), 3'($urandom_range(7)));
            end
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hold the reset period: a few ticks stay below it
        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_START);
        repeat (4)
            send(mqs_pkg::KIND_TICK, 3'($urandom_range(7)));
        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_RETURN);
        await_drain();

        write_period(16'd0);
        calm = 1'b1;
        foreach (drill[r])
            send_item(drill[r].kind, drill[r].key, drill[r].typed, drill[r].writes,
                      drill[r].col, drill[r].ch);
        calm = 1'b0;
        run_random(35);
        await_drain();

        write_period(16'd3);
        run_random(20);
        await_drain();
        run_random(20);
        await_drain();

        write_period(16'd1);
        calm = 1'b1;
        run_random(35);
        calm = 1'b0;
        await_drain();

        write_period(16'hFFFF);
        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_RETURN);
        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_START);
        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_DOWN);
        repeat (4)
            send(mqs_pkg::KIND_TICK, 3'($urandom_range(7)));
        send(mqs_pkg::KIND_KEY, mqs_pkg::KEY_RETURN);
        await_drain();

        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mqs_pkg.sv
rtl/mqs_msg_mem.sv
rtl/marquee_text_editor_scroller_core.sv
rtl/mqs_checker.sv
test/marquee_text_editor_scroller_core_tb.sv
